@@ rtl/bpps_pkg.sv @@
package bpps_pkg;

    // Field widths fixed by the interface
    localparam int NUM_W     = 10;
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 3;

    // Default geometry of the composite map
    localparam int MAX_NUMBER_DEF = 1023;
    localparam int WORD_BITS_DEF  = 32;

    // Register map (index into the register list, byte address is 4 * index)
    localparam int REG_LIMIT = 0;
    localparam logic [NUM_W-1:0] LIMIT_RESET = 10'd100;

    // Item function codes
    localparam logic FUNC_BUILD = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Sieve constants: the only even prime, and the first odd base
    localparam int PRIME_TWO = 2;
    localparam int FIRST_ODD = 3;

    // Odd base counter width: covers the first base whose square passes 1023
    localparam int I_W = 6;
    // Multiple counter width: a limit plus one stride
    localparam int J_W = NUM_W + 1;

    // Word/bit split by reciprocal multiply, exact for NUM_W-bit operands
    localparam int SPLIT_K = 16;
    localparam int RECIP_W = 17;

    // Operand of the word/bit split unit
    typedef enum logic [1:0] {
        SRC_NUM,
        SRC_I,
        SRC_J
    } split_src_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       latch_item;
        logic       clr_en;
        split_src_t split_src;
        logic       do_split;
        logic       do_read;
        logic       i_step;
        logic       j_init;
        logic       j_step;
        logic       mark_write;
        logic       commit_build;
        logic       load_query;
        logic       load_build;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;
        logic i_sq_over;
        logic j_over;
        logic map_bit;
    } dp_status_t;

endpackage

@@ rtl/bpps_datapath.sv @@
module bpps_datapath #(
    parameter int MAX_NUMBER = bpps_pkg::MAX_NUMBER_DEF,
    parameter int WORD_BITS  = bpps_pkg::WORD_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bpps_pkg::dp_cmd_t          cmd,
    output bpps_pkg::dp_status_t       status,
    input  logic [bpps_pkg::NUM_W-1:0] number,
    input  logic [bpps_pkg::NUM_W-1:0] limit,
    output logic                       is_prime,
    output logic                       out_of_range,
    output logic                       build_done
);

    localparam int NUM_W = bpps_pkg::NUM_W;
    localparam int I_W   = bpps_pkg::I_W;
    localparam int J_W   = bpps_pkg::J_W;
    localparam int WORDS = (MAX_NUMBER + WORD_BITS) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = $clog2(WORD_BITS);
    localparam int RECIP_W = bpps_pkg::RECIP_W;
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << bpps_pkg::SPLIT_K) + WORD_BITS - 1) / WORD_BITS);

    // Composite map
    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] rdata_reg;

    logic [NUM_W-1:0]     num_reg;
    logic [NUM_W-1:0]     lim_reg;
    logic [NUM_W-1:0]     built_lim_reg;
    logic                 built_valid_reg;
    logic [I_W-1:0]       i_reg;
    logic [J_W-1:0]       j_reg;
    logic [NUM_W-1:0]     q_reg;
    logic [BW-1:0]        r_reg;
    logic [AW-1:0]        clr_cnt_reg;
    logic                 is_prime_reg;
    logic                 oor_reg;
    logic                 done_reg;

    logic [NUM_W-1:0]     src;
    logic [PROD_W-1:0]    prod;
    logic [NUM_W-1:0]     rem_full;
    logic [AW-1:0]        word_addr;
    logic [2*I_W-1:0]     i_sq;
    logic [NUM_W-1:0]     lim_sat;
    logic                 q_oor;
    logic                 q_prime;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // Select the split operand; multiples are split only while within the limit
    always_comb begin
        case (cmd.split_src)
            bpps_pkg::SRC_NUM: src = num_reg;
            bpps_pkg::SRC_I:   src = NUM_W'(i_reg);
            bpps_pkg::SRC_J:   src = j_reg[NUM_W-1:0];
            default:           src = num_reg;
        endcase
    end

    // Word index by reciprocal multiply, bit index by remainder
    assign prod      = PROD_W'(src) * PROD_W'(RECIP);
    assign rem_full  = src - NUM_W'(q_reg * NUM_W'(WORD_BITS));
    assign word_addr = (32'(q_reg) < 32'(WORDS)) ? AW'(q_reg) : '0;

    assign i_sq    = (2*I_W)'(i_reg) * (2*I_W)'(i_reg);
    assign lim_sat = (32'(limit) > 32'(MAX_NUMBER)) ? NUM_W'(MAX_NUMBER) : limit;

    assign status.clr_last  = (clr_cnt_reg == AW'(WORDS - 1));
    assign status.i_sq_over = (i_sq > (2*I_W)'(lim_reg));
    assign status.j_over    = (j_reg > J_W'(lim_reg));
    assign status.map_bit   = rdata_reg[r_reg];

    // Query answer from the looked-up map word
    always_comb begin
        q_oor   = !built_valid_reg || (num_reg > built_lim_reg);
        q_prime = 1'b0;
        if (q_oor) begin
            q_prime = 1'b0;
        end else if (num_reg == NUM_W'(bpps_pkg::PRIME_TWO)) begin
            q_prime = 1'b1;
        end else if (num_reg < NUM_W'(bpps_pkg::PRIME_TWO) || !num_reg[0]) begin
            q_prime = 1'b0;
        end else begin
            q_prime = !status.map_bit;
        end
    end

    // Map write port: clear sweep or marking of one multiple
    assign wr_en   = cmd.clr_en || cmd.mark_write;
    assign wr_addr = cmd.clr_en ? clr_cnt_reg : word_addr;
    assign wr_data = cmd.clr_en ? '0 :
                     (rdata_reg | (WORD_BITS'(1) << r_reg));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.do_read) begin
            rdata_reg <= mem[word_addr];
        end
    end

    // Working registers of the sieve
    always_ff @(posedge aclk) begin
        if (cmd.latch_item) begin
            num_reg     <= number;
            lim_reg     <= lim_sat;
            clr_cnt_reg <= '0;
            i_reg       <= I_W'(bpps_pkg::FIRST_ODD);
        end
        if (cmd.clr_en) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
        if (cmd.do_split) begin
            q_reg <= NUM_W'(prod >> bpps_pkg::SPLIT_K);
        end
        if (cmd.do_read) begin
            r_reg <= rem_full[BW-1:0];
        end
        if (cmd.i_step) begin
            i_reg <= i_reg + I_W'(2);
        end
        if (cmd.j_init) begin
            j_reg <= J_W'(i_sq);
        end
        if (cmd.j_step) begin
            j_reg <= j_reg + J_W'({i_reg, 1'b0});
        end
        if (cmd.load_query) begin
            is_prime_reg <= q_prime;
            oor_reg      <= q_oor;
            done_reg     <= 1'b0;
        end
        if (cmd.load_build) begin
            is_prime_reg <= 1'b0;
            oor_reg      <= 1'b0;
            done_reg     <= 1'b1;
        end
    end

    // Record the completed build
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            built_valid_reg <= 1'b0;
            built_lim_reg   <= '0;
        end else if (cmd.commit_build) begin
            built_valid_reg <= 1'b1;
            built_lim_reg   <= lim_reg;
        end
    end

    assign is_prime     = is_prime_reg;
    assign out_of_range = oor_reg;
    assign build_done   = done_reg;

endmodule

@@ rtl/bpps_ctrl.sv @@
module bpps_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_func,
    output logic                   m_valid,
    input  logic                   m_ready,
    output bpps_pkg::dp_cmd_t      cmd,
    input  bpps_pkg::dp_status_t   status
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_I_TEST,
        ST_I_SPLIT,
        ST_I_READ,
        ST_I_DATA,
        ST_M_TEST,
        ST_M_SPLIT,
        ST_M_READ,
        ST_M_WRITE,
        ST_B_DONE,
        ST_Q_SPLIT,
        ST_Q_READ,
        ST_Q_DATA
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   accept;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // Sequence the build and query walks
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.split_src = bpps_pkg::SRC_NUM;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.latch_item = 1'b1;
                    state_next = (s_func == bpps_pkg::FUNC_BUILD) ? ST_CLEAR : ST_Q_SPLIT;
                end
            end
            ST_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_I_TEST;
                end
            end
            ST_I_TEST: begin
                state_next = status.i_sq_over ? ST_B_DONE : ST_I_SPLIT;
            end
            ST_I_SPLIT: begin
                cmd.split_src = bpps_pkg::SRC_I;
                cmd.do_split  = 1'b1;
                state_next    = ST_I_READ;
            end
            ST_I_READ: begin
                cmd.split_src = bpps_pkg::SRC_I;
                cmd.do_read   = 1'b1;
                state_next    = ST_I_DATA;
            end
            ST_I_DATA: begin
                // Skip bases already marked composite
                if (status.map_bit) begin
                    cmd.i_step = 1'b1;
                    state_next = ST_I_TEST;
                end else begin
                    cmd.j_init = 1'b1;
                    state_next = ST_M_TEST;
                end
            end
            ST_M_TEST: begin
                if (status.j_over) begin
                    cmd.i_step = 1'b1;
                    state_next = ST_I_TEST;
                end else begin
                    state_next = ST_M_SPLIT;
                end
            end
            ST_M_SPLIT: begin
                cmd.split_src = bpps_pkg::SRC_J;
                cmd.do_split  = 1'b1;
                state_next    = ST_M_READ;
            end
            ST_M_READ: begin
                cmd.split_src = bpps_pkg::SRC_J;
                cmd.do_read   = 1'b1;
                state_next    = ST_M_WRITE;
            end
            ST_M_WRITE: begin
                cmd.mark_write = 1'b1;
                cmd.j_step     = 1'b1;
                state_next     = ST_M_TEST;
            end
            ST_B_DONE: begin
                if (out_free) begin
                    cmd.commit_build = 1'b1;
                    cmd.load_build   = 1'b1;
                    m_valid_next     = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_Q_SPLIT: begin
                cmd.do_split = 1'b1;
                state_next   = ST_Q_READ;
            end
            ST_Q_READ: begin
                cmd.do_read = 1'b1;
                state_next  = ST_Q_DATA;
            end
            ST_Q_DATA: begin
                // Hold the answer until the output register frees up
                if (out_free) begin
                    cmd.load_query = 1'b1;
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ rtl/bit_packed_prime_sieve_top.sv @@
// Prime sieve over a bit-packed composite map of (MAX_NUMBER + WORD_BITS) / WORD_BITS
// words. A build transaction (func 0) clears the map, then walks odd bases i with
// i*i <= limit and marks their odd multiples; a query transaction (func 1) answers
// whether number is prime against the limit of the last build, flagging out_of_range
// above it or before any build. Every transaction returns exactly one result. The map
// has one read and one write port, so a query runs as split of the number into word
// and bit, map read, then answer, held until the result register is free. A build
// clears the map one word at a time, then per odd base tests, splits and reads its
// map bit, and per marked multiple tests, splits, reads and writes the map word; input
// stays stalled meanwhile. The limit register is sampled when a build is accepted and
// saturates at MAX_NUMBER.
module bit_packed_prime_sieve_top #(
    parameter int MAX_NUMBER = bpps_pkg::MAX_NUMBER_DEF,
    parameter int WORD_BITS  = bpps_pkg::WORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bpps_pkg::PADDR_W-1:0] paddr,
    input  logic [bpps_pkg::PDATA_W-1:0] pwdata,
    output logic [bpps_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    // Input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_func,
    input  logic [bpps_pkg::NUM_W-1:0]   s_number,
    // Result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_is_prime,
    output logic                         m_out_of_range,
    output logic                         m_build_done
);

    localparam int NUM_W = bpps_pkg::NUM_W;
    localparam int REG_W = bpps_pkg::PADDR_W - 2;

    logic [NUM_W-1:0]     limit_reg;
    logic                 limit_sel;
    bpps_pkg::dp_cmd_t    cmd;
    bpps_pkg::dp_status_t status;

    assign pready    = 1'b1;
    assign limit_sel = (paddr[bpps_pkg::PADDR_W-1:2] == REG_W'(bpps_pkg::REG_LIMIT));

    // Write the limit register on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= bpps_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite && limit_sel) begin
            limit_reg <= pwdata[NUM_W-1:0];
        end
    end

    assign prdata = limit_sel ? bpps_pkg::PDATA_W'(limit_reg) : '0;

    bpps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    bpps_datapath #(
        .MAX_NUMBER (MAX_NUMBER),
        .WORD_BITS  (WORD_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .number       (s_number),
        .limit        (limit_reg),
        .is_prime     (m_is_prime),
        .out_of_range (m_out_of_range),
        .build_done   (m_build_done)
    );

endmodule

@@ rtl/bpps_checker.sv @@
module bpps_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_is_prime,
    input logic                         m_out_of_range,
    input logic                         m_build_done
);

    // A build acknowledgement carries no query answer
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_build_done |-> !m_is_prime && !m_out_of_range)
        else $error("build result carries query flags");

    // An out-of-range query never answers prime
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_of_range |-> !m_is_prime)
        else $error("out-of-range result marked prime");

    // No result right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_prime)
            && $stable(m_out_of_range) && $stable(m_build_done))
        else $error("stalled result changed");

    // Drop ready once a transaction is taken: one transaction at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a transaction");

endmodule

bind bit_packed_prime_sieve_top bpps_checker u_bpps_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_is_prime     (m_is_prime),
    .m_out_of_range (m_out_of_range),
    .m_build_done   (m_build_done)
);
